[design/byte_stream_tokenizer_top_assert.svh]
// Assertion macros used by the tokenizer top level.
`ifndef BYTE_STREAM_TOKENIZER_TOP_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define BST_ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BST_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

[design/bst_pkg.sv]
// Shared types, constants and character classes for the byte stream tokenizer.
`default_nettype none

package bst_pkg;

  localparam int MAX_TEXT_CHARS_DEF = 8;
  localparam int POSITION_BITS_DEF  = 16;
  localparam int NUMBER_BITS_DEF    = 32;

  // Result queue sizing.
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
  localparam int Q_LEVEL_BITS = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    TOK_NEWLINE  = 4'd0,
    TOK_PLUS     = 4'd1,
    TOK_MINUS    = 4'd2,
    TOK_STAR     = 4'd3,
    TOK_ASSIGN   = 4'd4,
    TOK_LBRACKET = 4'd5,
    TOK_RBRACKET = 4'd6,
    TOK_LPAREN   = 4'd7,
    TOK_RPAREN   = 4'd8,
    TOK_COMMA    = 4'd9,
    TOK_NUMBER   = 4'd10,
    TOK_IDENT    = 4'd11,
    TOK_MATRIX   = 4'd12,
    TOK_PRINT    = 4'd13,
    TOK_EOF      = 4'd14,
    TOK_ERROR    = 4'd15
  } tok_kind_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_UNDER   = "_";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_ASSIGN  = "=";
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_RBRACK  = "]";
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_COMMA   = ",";

  // Packed lexeme text, first character in the lowest byte.
  localparam logic [63:0] TEXT_MATRIX  = 64'h0000_7869_7274_616D;
  localparam logic [63:0] TEXT_PRINT   = 64'h0000_0074_6E69_7270;
  localparam logic [63:0] TEXT_NEWLINE = 64'h0000_0000_0000_6E5C;
  localparam logic [7:0]  LEN_MATRIX   = 8'd6;
  localparam logic [7:0]  LEN_PRINT    = 8'd5;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  lexeme_length;
    logic [31:0] number_value;
    logic [63:0] lexeme_text;
    logic        overflow_flag;
    logic        last_of_run;
  } tok_item_t;

  // Up to two tokens produced by one accepted item.
  typedef struct packed {
    logic [1:0] count;
    tok_item_t  first;
    tok_item_t  second;
  } tok_push_t;

  typedef struct packed {
    logic [Q_LEVEL_BITS-1:0] level;
    logic                    room_for_two;
  } q_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) || (b == CH_ASSIGN) ||
           (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_COMMA);
  endfunction

  function automatic tok_kind_t op_kind(input logic [7:0] b);
    tok_kind_t k;
    case (b)
      CH_PLUS:   k = TOK_PLUS;
      CH_MINUS:  k = TOK_MINUS;
      CH_STAR:   k = TOK_STAR;
      CH_ASSIGN: k = TOK_ASSIGN;
      CH_LBRACK: k = TOK_LBRACKET;
      CH_RBRACK: k = TOK_RBRACKET;
      CH_LPAREN: k = TOK_LPAREN;
      CH_RPAREN: k = TOK_RPAREN;
      CH_COMMA:  k = TOK_COMMA;
      default:   k = TOK_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[design/bst_scan.sv]
// Scanner core: scan mode, position counters, pending lexeme and token formation.
`default_nettype none

module bst_scan #(
  parameter int MAX_TEXT_CHARS = bst_pkg::MAX_TEXT_CHARS_DEF,
  parameter int POSITION_BITS  = bst_pkg::POSITION_BITS_DEF,
  parameter int NUMBER_BITS    = bst_pkg::NUMBER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  bst_pkg::src_item_t item,
  output bst_pkg::tok_push_t push
);
  import bst_pkg::*;

  localparam int TEXT_BITS = 8 * MAX_TEXT_CHARS;
  localparam int PROD_BITS = NUMBER_BITS + 4;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUMBER  = 5'b00010,
    MODE_IDENT   = 5'b00100,
    MODE_COMMENT = 5'b01000,
    MODE_STOPPED = 5'b10000
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] line, line_next;
  logic [POSITION_BITS-1:0] column, column_next;
  logic [POSITION_BITS-1:0] start_column, start_column_next;
  logic [NUMBER_BITS-1:0]   value, value_next;
  logic [7:0]               length, length_next;
  logic [TEXT_BITS-1:0]     text, text_next;
  logic                     overflow, overflow_next;

  logic [7:0]               b;
  logic [POSITION_BITS-1:0] col_inc;
  logic [PROD_BITS-1:0]     prod;
  logic                     prod_ovf;
  logic                     pending;
  tok_item_t                pend_tok, idle_tok, eof_tok, sec_tok;
  logic                     idle_emit;
  logic                     run_idle, extend, emit_pend, emit_sec;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] p);
    return (&p) ? p : p + POS_ONE;
  endfunction

  assign b        = item.source_byte;
  assign col_inc  = pos_inc(column);
  assign pending  = (mode == MODE_NUMBER) || (mode == MODE_IDENT);
  assign prod     = (PROD_BITS'(value) << 3) + (PROD_BITS'(value) << 1)
                  + PROD_BITS'(b[3:0]);
  assign prod_ovf = |prod[PROD_BITS-1:NUMBER_BITS];

  // Token for the pending number or identifier.
  always_comb begin
    pend_tok               = '0;
    pend_tok.start_line    = 16'(line);
    pend_tok.start_column  = 16'(start_column);
    pend_tok.lexeme_length = length;
    pend_tok.lexeme_text   = 64'(text);
    pend_tok.overflow_flag = overflow;
    if (mode == MODE_NUMBER) begin
      pend_tok.token_kind   = TOK_NUMBER;
      pend_tok.number_value = 32'(value);
    end else if (length == LEN_MATRIX && 64'(text) == TEXT_MATRIX) begin
      pend_tok.token_kind = TOK_MATRIX;
    end else if (length == LEN_PRINT && 64'(text) == TEXT_PRINT) begin
      pend_tok.token_kind = TOK_PRINT;
    end else begin
      pend_tok.token_kind = TOK_IDENT;
    end
  end

  // Token a byte gives when it is scanned from idle.
  always_comb begin
    idle_tok               = '0;
    idle_tok.start_line    = 16'(line);
    idle_tok.start_column  = 16'(column);
    idle_tok.lexeme_length = 8'd1;
    idle_tok.lexeme_text   = 64'(b);
    idle_emit              = 1'b1;
    if (b == CH_NEWLINE) begin
      idle_tok.token_kind    = TOK_NEWLINE;
      idle_tok.lexeme_length = 8'd2;
      idle_tok.lexeme_text   = TEXT_NEWLINE;
    end else if (is_op(b)) begin
      idle_tok.token_kind = op_kind(b);
    end else if (is_blank(b) || b == CH_HASH || is_digit(b) || is_alpha(b)) begin
      idle_emit = 1'b0;
    end else begin
      idle_tok.token_kind = TOK_ERROR;
    end
  end

  always_comb begin
    eof_tok              = '0;
    eof_tok.token_kind   = TOK_EOF;
    eof_tok.start_line   = 16'(line);
    eof_tok.start_column = 16'(column);
  end

  always_comb begin
    mode_next         = mode;
    line_next         = line;
    column_next       = column;
    start_column_next = start_column;
    value_next        = value;
    length_next       = length;
    text_next         = text;
    overflow_next     = overflow;
    run_idle          = 1'b0;
    extend            = 1'b0;
    emit_pend         = 1'b0;
    emit_sec          = 1'b0;
    sec_tok           = idle_tok;

    if (accept) begin
      if (item.end_of_source) begin
        emit_pend         = pending;
        emit_sec          = 1'b1;
        sec_tok           = eof_tok;
        mode_next         = MODE_IDLE;
        line_next         = POS_ONE;
        column_next       = POS_ONE;
        start_column_next = POS_ONE;
        value_next        = '0;
        length_next       = '0;
        text_next         = '0;
        overflow_next     = 1'b0;
      end else begin
        case (mode)
          MODE_STOPPED: begin
          end
          MODE_COMMENT: begin
            if (b == CH_NEWLINE) begin
              run_idle = 1'b1;
            end else begin
              column_next = col_inc;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(b)) begin
              extend = 1'b1;
            end else begin
              emit_pend = 1'b1;
              run_idle  = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b)) begin
              extend = 1'b1;
            end else begin
              emit_pend = 1'b1;
              run_idle  = 1'b1;
            end
          end
          default: begin
            run_idle = 1'b1;
          end
        endcase
      end
    end

    if (extend) begin
      for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
        if (length == 8'(i)) begin
          text_next[8*i +: 8] = b;
        end
      end
      length_next = (&length) ? length : length + 8'd1;
      if (mode == MODE_NUMBER) begin
        if (prod_ovf) begin
          value_next    = '1;
          overflow_next = 1'b1;
        end else begin
          value_next = prod[NUMBER_BITS-1:0];
        end
      end else if (length_next > 8'(MAX_TEXT_CHARS)) begin
        overflow_next = 1'b1;
      end
      column_next = col_inc;
    end

    // A byte that ends a lexeme is then scanned as if from idle.
    if (run_idle) begin
      mode_next = MODE_IDLE;
      emit_sec  = idle_emit;
      if (b == CH_NEWLINE) begin
        line_next   = pos_inc(line);
        column_next = POS_ONE;
      end else begin
        column_next = col_inc;
      end
      if (b == CH_HASH) begin
        mode_next = MODE_COMMENT;
      end else if (is_digit(b) || is_alpha(b)) begin
        mode_next         = is_digit(b) ? MODE_NUMBER : MODE_IDENT;
        start_column_next = column;
        value_next        = is_digit(b) ? NUMBER_BITS'(b[3:0]) : '0;
        length_next       = 8'd1;
        text_next         = TEXT_BITS'(b);
        overflow_next     = 1'b0;
      end else if (idle_tok.token_kind == TOK_ERROR && idle_emit) begin
        mode_next = MODE_STOPPED;
      end
    end
  end

  always_comb begin
    push                    = '0;
    push.count              = 2'(emit_pend) + 2'(emit_sec);
    push.first              = emit_pend ? pend_tok : sec_tok;
    push.first.last_of_run  = !(emit_pend && emit_sec);
    push.second             = sec_tok;
    push.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      line         <= POS_ONE;
      column       <= POS_ONE;
      start_column <= POS_ONE;
      value        <= '0;
      length       <= '0;
      text         <= '0;
      overflow     <= 1'b0;
    end else begin
      mode         <= mode_next;
      line         <= line_next;
      column       <= column_next;
      start_column <= start_column_next;
      value        <= value_next;
      length       <= length_next;
      text         <= text_next;
      overflow     <= overflow_next;
    end
  end

endmodule

`default_nettype wire

[design/bst_queue.sv]
// Result queue: takes up to two tokens a cycle and hands out one unless stalled.
`default_nettype none

module bst_queue (
  input  logic               clk,
  input  logic               rst,
  input  bst_pkg::tok_push_t push,
  input  logic               stall,
  output logic               valid,
  output bst_pkg::tok_item_t item,
  output bst_pkg::q_status_t status
);
  import bst_pkg::*;

  tok_item_t               slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr, rd_ptr, wr_ptr_plus;
  logic [Q_LEVEL_BITS-1:0] level;
  logic                    pop;

  assign valid       = (level != '0);
  assign item        = slots[rd_ptr];
  assign pop         = valid && !stall;
  assign wr_ptr_plus = wr_ptr + Q_PTR_BITS'(1);

  assign status.level        = level;
  assign status.room_for_two = (level <= Q_LEVEL_BITS'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + Q_PTR_BITS'(pop);
      level  <= level + Q_LEVEL_BITS'(push.count) - Q_LEVEL_BITS'(pop);
    end
  end

endmodule

`default_nettype wire

[design/byte_stream_tokenizer_top.sv]
// Top level of the byte stream tokenizer: scanner core feeding a result queue.
`default_nettype none

// The tokenizer takes one source byte, or an end-of-source marker, per item and
// returns token records on the output channel; last_of_run marks the final token
// caused by an item. An item is scanned in the cycle it is accepted, so bytes are
// taken at one per clock while src_stall is low. Most items give zero or one token;
// a byte that ends a number or identifier and is itself a token, or the end marker
// after a pending lexeme, gives two, and the single output port hands them out one
// at a time. Tokens wait in a four-entry queue; the input stalls whenever fewer than
// two entries are free, so the sustained rate is one item per cycle as long as the
// output drains at least as fast as tokens are produced. After a bad byte the block
// drops bytes until the end marker, which also returns it to its reset state.
module byte_stream_tokenizer_top #(
  parameter int MAX_TEXT_CHARS = bst_pkg::MAX_TEXT_CHARS_DEF,
  parameter int POSITION_BITS  = bst_pkg::POSITION_BITS_DEF,
  parameter int NUMBER_BITS    = bst_pkg::NUMBER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  bst_pkg::src_item_t src_item,
  output logic               tok_valid,
  input  logic               tok_stall,
  output bst_pkg::tok_item_t tok_item
);
  import bst_pkg::*;

  logic      accept;
  tok_push_t push;
  q_status_t q_status;

  assign src_stall = !q_status.room_for_two;
  assign accept    = src_valid && !src_stall;

  bst_scan #(
    .MAX_TEXT_CHARS(MAX_TEXT_CHARS),
    .POSITION_BITS (POSITION_BITS),
    .NUMBER_BITS   (NUMBER_BITS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (src_item),
    .push  (push)
  );

  bst_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .stall (tok_stall),
    .valid (tok_valid),
    .item  (tok_item),
    .status(q_status)
  );

`include "byte_stream_tokenizer_top_assert.svh"

  `BST_ASSERT_IMPLY(a_push_needs_accept, push.count != 2'd0, accept, "token pushed without an accepted item")
  `BST_ASSERT_ALWAYS(a_queue_bound, q_status.level <= Q_LEVEL_BITS'(Q_DEPTH), "result queue overfilled")
  `BST_ASSERT_NEXT(a_eof_queued, accept && src_item.end_of_source, tok_valid, "end marker gave no token")
  `BST_ASSERT_IMPLY(a_eof_shape, tok_valid && tok_item.token_kind == TOK_EOF, tok_item.lexeme_length == 8'd0 && tok_item.last_of_run, "malformed end-of-file token")

endmodule

`default_nettype wire
